/* rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the circular deque
// Word type, command and status codes, cell operations, neighbour link and
// controller states.
// ----------------------------------------------------------------------------
package cdq_pkg;

  typedef logic signed [31:0] word_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_REAR  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_R,
    CELL_SHIFT_L,
    CELL_PUT_REAR,
    CELL_TAKE_REAR
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_t;

  // What one cell shows to its neighbours: a word and whether it is held.
  typedef struct packed {
    logic  vld;
    word_t word;
  } link_t;

  localparam word_t EMPTY_WORD = -32'sd1;

endpackage

/* rtl/cdq_cell.sv */
// ----------------------------------------------------------------------------
// cdq_cell: one slot of the deque row
// Holds one word with its valid flag, shifts with its neighbours, and
// carries a word taken from the rear along the return lane toward cell 0.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic              clk,
  input  logic              rst,
  input  cdq_pkg::cell_op_t op,
  input  cdq_pkg::word_t    put_word,
  input  cdq_pkg::link_t    left,
  input  cdq_pkg::link_t    right,
  input  cdq_pkg::link_t    lane_in,
  output cdq_pkg::link_t    own,
  output cdq_pkg::link_t    lane_out
);
  import cdq_pkg::*;

  logic  vld, vld_next;
  word_t word, word_next;
  logic  lane_vld, lane_vld_next;
  word_t lane_word, lane_word_next;
  logic  is_last;
  logic  is_slot;

  // Rear entry: held here, nothing held to the right.
  assign is_last = vld & ~right.vld;
  // First free slot: empty here, held to the left.
  assign is_slot = ~vld & left.vld;

  always_comb begin
    vld_next  = vld;
    word_next = word;
    unique case (op)
      CELL_SHIFT_R: begin
        vld_next  = left.vld;
        word_next = left.word;
      end
      CELL_SHIFT_L: begin
        vld_next  = right.vld;
        word_next = right.word;
      end
      CELL_PUT_REAR: begin
        if (is_slot) begin
          vld_next  = 1'b1;
          word_next = put_word;
        end
      end
      CELL_TAKE_REAR: begin
        if (is_last) vld_next = 1'b0;
      end
      default: begin
        vld_next  = vld;
        word_next = word;
      end
    endcase

    if ((op == CELL_TAKE_REAR) && is_last) begin
      lane_vld_next  = 1'b1;
      lane_word_next = word;
    end else begin
      lane_vld_next  = lane_in.vld;
      lane_word_next = lane_in.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= 1'b0;
      lane_vld <= 1'b0;
    end else begin
      vld      <= vld_next;
      lane_vld <= lane_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    word      <= word_next;
    lane_word <= lane_word_next;
  end

  assign own      = '{vld: vld, word: word};
  assign lane_out = '{vld: lane_vld, word: lane_word};

endmodule

/* rtl/circular_deque_top.sv */
// ----------------------------------------------------------------------------
// circular_deque_top: double-ended queue of signed 32-bit words
// A row of DEPTH cells holds the deque front-aligned at cell 0; a small
// controller keeps the count and registers one result word per command.
// ----------------------------------------------------------------------------
// Each accepted command word gives exactly one result word. The result of
// push front, push rear and pop front is registered at the accepting edge and
// shown in the cycle that follows. The next command may be taken at the
// following edge, provided the result leaves at that edge. Pop rear on a
// non-empty deque holding n entries captures the rear word at the accepting
// edge in the return lane of its own cell, cell n - 1. It then walks the lane
// one cell a cycle down to cell 0. The result is registered once the word
// reaches cell 0, and the input is stalled until then. A push while full
// answers status 1. A pop while empty answers status 2 with data all ones.
// Neither changes the contents. Occupancy is the count after the command,
// masked to 8 bits.
// ----------------------------------------------------------------------------
module circular_deque_top #(
  parameter int DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  cdq_pkg::word_t      value,
  output logic                out_valid,
  input  logic                out_stall,
  output cdq_pkg::word_t      data,
  output logic [1:0]          status,
  output logic [7:0]          occupancy
);
  import cdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  state_t         state, state_next;
  logic [CW-1:0]  count, count_next;
  logic           out_vld, out_vld_next;
  word_t          out_data, out_data_next;
  status_t        out_status, out_status_next;
  logic [7:0]     out_occ, out_occ_next;
  logic           accept;
  cell_op_t       cell_op;
  logic [CW+7:0]  occ_ext;

  link_t          own   [DEPTH];
  link_t          lane  [DEPTH];
  logic [DEPTH-1:0] vld_vec;

  // The row of cells: cell 0 sees the incoming word as its left neighbour,
  // the last cell sees nothing held to its right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t left_l, right_l, lane_l;
    if (i == 0) begin : g_first
      assign left_l = '{vld: 1'b1, word: value};
    end else begin : g_mid_l
      assign left_l = own[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_l = '0;
      assign lane_l  = '0;
    end else begin : g_mid_r
      assign right_l = own[i+1];
      assign lane_l  = lane[i+1];
    end

    cdq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .op       (cell_op),
      .put_word (value),
      .left     (left_l),
      .right    (right_l),
      .lane_in  (lane_l),
      .own      (own[i]),
      .lane_out (lane[i])
    );

    assign vld_vec[i] = own[i].vld;
  end

  // Stall while a rear word is in flight or the result slot stays occupied.
  assign in_stall = (state == S_WAIT) | (out_vld & out_stall);
  assign accept   = in_valid & ~in_stall;

  // Mask the count to the 8-bit occupancy field.
  assign occ_ext  = {8'd0, count_next};

  always_comb begin
    state_next      = state;
    count_next      = count;
    out_vld_next    = out_vld & out_stall;
    out_data_next   = out_data;
    out_status_next = out_status;
    out_occ_next    = out_occ;
    cell_op         = CELL_HOLD;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          out_vld_next    = 1'b1;
          out_data_next   = '0;
          out_status_next = STAT_DONE;
          unique case (cmd_t'(cmd))
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              if (count == CW'(DEPTH)) begin
                out_status_next = STAT_FULL;
              end else begin
                cell_op    = (cmd_t'(cmd) == CMD_PUSH_FRONT) ? CELL_SHIFT_R : CELL_PUT_REAR;
                count_next = count + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (count == '0) begin
                out_data_next   = EMPTY_WORD;
                out_status_next = STAT_EMPTY;
              end else begin
                // Front word sits in cell 0; shift the row down behind it.
                out_data_next = own[0].word;
                cell_op       = CELL_SHIFT_L;
                count_next    = count - CW'(1);
              end
            end
            CMD_POP_REAR: begin
              if (count == '0) begin
                out_data_next   = EMPTY_WORD;
                out_status_next = STAT_EMPTY;
              end else begin
                // Drop the rear entry and wait for it on the return lane.
                cell_op      = CELL_TAKE_REAR;
                count_next   = count - CW'(1);
                out_vld_next = 1'b0;
                state_next   = S_WAIT;
              end
            end
            default: begin
              out_status_next = STAT_DONE;
            end
          endcase
          out_occ_next = occ_ext[7:0];
        end
      end
      S_WAIT: begin
        if (lane[0].vld) begin
          out_vld_next    = 1'b1;
          out_data_next   = lane[0].word;
          out_status_next = STAT_DONE;
          out_occ_next    = occ_ext[7:0];
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      out_vld <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    out_data   <= out_data_next;
    out_status <= out_status_next;
    out_occ    <= out_occ_next;
  end

  assign out_valid = out_vld;
  assign data      = out_data;
  assign status    = out_status;
  assign occupancy = out_occ;

  // Count never runs past the row.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("deque count beyond depth");

  // Held cells always match the count.
  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(vld_vec) == int'(count))
    else $error("cell valid flags disagree with count");

  // No result is shown while a rear word is in flight.
  a_wait_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> !out_vld)
    else $error("result shown during rear pop");

  // The return lane only reaches cell 0 while it is awaited.
  a_lane_expected: assert property (@(posedge clk) disable iff (rst)
    lane[0].vld |-> (state == S_WAIT))
    else $error("unexpected word on return lane");

endmodule
